>>> design/fdm_pkg.sv
// Package for the frame deadline monitor: payload structs, event and register codes,
// and the layout of one per-task statistics entry.
// No dependencies; every other design file imports it.
package fdm_pkg;

    localparam int MASK_W   = 6;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        MODE_ADMIT      = 2'd0,
        MODE_JOB_DONE   = 2'd1,
        MODE_FRAME_DONE = 2'd2,
        MODE_OVERRUN    = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_LEN     = 3'd0,
        REG_SLACK_THR     = 3'd1,
        REG_DEGRADED_HP   = 3'd2,
        REG_CRIT_MASK     = 3'd3,
        REG_OVERLOAD_EN   = 3'd4,
        REG_RECOVERY_EN   = 3'd5,
        REG_STATS_EN      = 3'd6,
        REG_STREAK_LIMIT  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        mode_t       mode;
        logic [2:0]  task_id;
        logic [31:0] duration_us;
        logic [63:0] release_ts;
        logic [63:0] start_ts;
        logic [63:0] stop_us;
        logic        last_frame;
    } in_item_t;

    typedef struct packed {
        logic               skip;
        logic [31:0]        stat_min_us;
        logic [31:0]        stat_max_us;
        logic [63:0]        stat_sum_us;
        logic [31:0]        stat_count;
        logic [63:0]        start_jitter;
        logic signed [63:0] frame_slack;
        logic               deadline_miss;
        logic               slack_warn;
        logic [3:0]         degraded_left;
        logic               reboot_request;
        logic [31:0]        fault_total;
    } out_item_t;

    typedef struct packed {
        logic [31:0] min_us;
        logic [31:0] max_us;
        logic [63:0] sum_us;
        logic [31:0] count;
    } stat_entry_t;

    localparam stat_entry_t STAT_INIT = '{
        min_us:   32'hFFFF_FFFF,
        max_us:   32'd0,
        sum_us:   64'd0,
        count:    32'd0
    };

endpackage

>>> design/frame_deadline_monitor_top.sv
// Top level of the frame deadline monitor: configuration registers, event execution
// and the output register. Depends on fdm_pkg and fdm_stat_mem.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_ready     in_data   (fdm_pkg::in_item_t)
//   out      output     out_valid / out_ready   out_data  (fdm_pkg::out_item_t)
//   cfg      input      cfg_we                  cfg_index, cfg_data
//
// The accepting edge reads the task's statistics entry; execution then updates it,
// writes it back (job-done with statistics on) and loads the output register.
// A new beat is taken in the cycle after the previous event finished executing, even
// while its result still waits in the output register. A stalled output holds the
// executing event. Reset restores register defaults and empties the pipeline; the
// statistics table reads as cleared through per-entry written bits, with no sweep.
module frame_deadline_monitor_top #(
    parameter int NUM_TASKS = 6
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  fdm_pkg::in_item_t         in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output fdm_pkg::out_item_t        out_data,
    input  logic                      cfg_we,
    input  logic [fdm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fdm_pkg::CFG_W-1:0] cfg_data
);
    import fdm_pkg::*;

    localparam int AW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    // Configuration registers.
    logic [31:0]       frame_len_reg;
    logic [31:0]       slack_thr_reg;
    logic [3:0]        degraded_hp_reg;
    logic [MASK_W-1:0] crit_mask_reg;
    logic              overload_en_reg;
    logic              recovery_en_reg;
    logic              stats_en_reg;
    logic [7:0]        streak_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_len_reg    <= 32'd10000;
            slack_thr_reg    <= 32'd500;
            degraded_hp_reg  <= 4'd2;
            crit_mask_reg    <= 6'd3;
            overload_en_reg  <= 1'b0;
            recovery_en_reg  <= 1'b0;
            stats_en_reg     <= 1'b1;
            streak_limit_reg <= 8'd2;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_FRAME_LEN:    frame_len_reg    <= cfg_data;
                REG_SLACK_THR:    slack_thr_reg    <= cfg_data;
                REG_DEGRADED_HP:  degraded_hp_reg  <= cfg_data[3:0];
                REG_CRIT_MASK:    crit_mask_reg    <= cfg_data[MASK_W-1:0];
                REG_OVERLOAD_EN:  overload_en_reg  <= cfg_data[0];
                REG_RECOVERY_EN:  recovery_en_reg  <= cfg_data[0];
                REG_STATS_EN:     stats_en_reg     <= cfg_data[0];
                REG_STREAK_LIMIT: streak_limit_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Pipeline control and monitor state.
    logic        exec_reg;
    logic        exec_next;
    in_item_t    item_reg;
    logic        task_ok_reg;
    logic        out_valid_reg;
    out_item_t   out_data_reg;
    logic [3:0]  degraded_reg;
    logic [3:0]  degraded_next;
    logic [31:0] faults_reg;
    logic [31:0] faults_next;
    logic        severe_hp_reg;
    logic        severe_hp_next;
    logic [7:0]  streak_reg;
    logic [7:0]  streak_next;

    logic        in_fire;
    logic        exec_fire;
    logic        in_task_ok;
    stat_entry_t rd_entry;
    stat_entry_t upd_entry;
    logic        stat_wr;
    out_item_t   result;

    assign in_ready   = !exec_reg;
    assign in_fire    = in_valid && in_ready;
    assign exec_fire  = exec_reg && (!out_valid_reg || out_ready);
    assign in_task_ok = 32'(in_data.task_id) < 32'(NUM_TASKS);
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    fdm_stat_mem #(
        .NUM_TASKS(NUM_TASKS),
        .AW(AW)
    ) u_stat_mem (
        .clk(clk),
        .rst_n(rst_n),
        .rd_en(in_fire && in_task_ok),
        .rd_addr(AW'(in_data.task_id)),
        .rd_data(rd_entry),
        .wr_en(stat_wr),
        .wr_addr(AW'(item_reg.task_id)),
        .wr_data(upd_entry)
    );

    // Event execution.
    logic [63:0] slack_bits;
    logic        slack_neg;
    logic        slack_low;
    logic        critical;
    logic        enter_degraded;
    logic        is_frame;
    logic        sev_now;
    logic [3:0]  deg_after_entry;

    always_comb
    begin
        is_frame   = (item_reg.mode == MODE_FRAME_DONE);
        slack_bits = item_reg.release_ts + {32'd0, frame_len_reg} - item_reg.stop_us;
        slack_neg  = slack_bits[63];
        slack_low  = !slack_neg && (slack_bits < {32'd0, slack_thr_reg});
        critical   = (32'(item_reg.task_id) < 32'(MASK_W)) ? crit_mask_reg[item_reg.task_id]
                                                          : 1'b0;

        upd_entry.min_us   = (item_reg.duration_us < rd_entry.min_us) ? item_reg.duration_us
                                                                      : rd_entry.min_us;
        upd_entry.max_us   = (item_reg.duration_us > rd_entry.max_us) ? item_reg.duration_us
                                                                      : rd_entry.max_us;
        upd_entry.sum_us   = rd_entry.sum_us + {32'd0, item_reg.duration_us};
        upd_entry.count    = rd_entry.count + 32'd1;

        stat_wr = exec_fire && (item_reg.mode == MODE_JOB_DONE) && task_ok_reg && stats_en_reg;

        enter_degraded = (is_frame && (slack_neg || slack_low))
                      || (item_reg.mode == MODE_OVERRUN);
        deg_after_entry = (enter_degraded && overload_en_reg) ? degraded_hp_reg : degraded_reg;

        faults_next = ((is_frame && slack_neg) || (item_reg.mode == MODE_OVERRUN))
                    ? faults_reg + 32'd1 : faults_reg;
        sev_now     = severe_hp_reg || (is_frame && slack_neg);

        degraded_next  = deg_after_entry;
        severe_hp_next = sev_now;
        streak_next    = streak_reg;
        result         = '0;
        result.stat_min_us = (item_reg.mode == MODE_JOB_DONE) ? STAT_INIT.min_us : 32'd0;

        // A hyperperiod end counts degraded mode down and scores the streak, each if enabled.
        if (is_frame && item_reg.last_frame)
        begin
            if (overload_en_reg && (deg_after_entry != 4'd0))
            begin
                degraded_next = deg_after_entry - 4'd1;
            end
            if (recovery_en_reg)
            begin
                if (sev_now)
                begin
                    streak_next = (streak_reg != 8'hFF) ? streak_reg + 8'd1 : streak_reg;
                end
                else
                begin
                    streak_next = 8'd0;
                end
                result.reboot_request = (streak_next >= streak_limit_reg);
            end
            severe_hp_next = 1'b0;
        end

        unique case (item_reg.mode)
            MODE_ADMIT:
            begin
                result.skip = overload_en_reg && (degraded_reg != 4'd0) && !critical;
            end
            MODE_JOB_DONE:
            begin
                if (task_ok_reg)
                begin
                    if (stats_en_reg)
                    begin
                        result.stat_min_us   = upd_entry.min_us;
                        result.stat_max_us   = upd_entry.max_us;
                        result.stat_sum_us   = upd_entry.sum_us;
                        result.stat_count    = upd_entry.count;
                    end
                    else
                    begin
                        result.stat_min_us   = rd_entry.min_us;
                        result.stat_max_us   = rd_entry.max_us;
                        result.stat_sum_us   = rd_entry.sum_us;
                        result.stat_count    = rd_entry.count;
                    end
                end
            end
            MODE_FRAME_DONE:
            begin
                result.start_jitter  = item_reg.start_ts - item_reg.release_ts;
                result.frame_slack   = slack_bits;
                result.deadline_miss = slack_neg;
                result.slack_warn    = slack_low;
            end
            MODE_OVERRUN: ;
            default: ;
        endcase

        result.degraded_left = degraded_next;
        result.fault_total   = faults_next;

        exec_next = in_fire ? 1'b1 : (exec_fire ? 1'b0 : exec_reg);
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg    <= in_data;
            task_ok_reg <= in_task_ok;
        end
        if (exec_fire)
        begin
            out_data_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exec_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            degraded_reg  <= 4'd0;
            faults_reg    <= 32'd0;
            severe_hp_reg <= 1'b0;
            streak_reg    <= 8'd0;
        end
        else
        begin
            exec_reg <= exec_next;
            if (exec_fire)
            begin
                out_valid_reg <= 1'b1;
                degraded_reg  <= degraded_next;
                faults_reg    <= faults_next;
                severe_hp_reg <= severe_hp_next;
                streak_reg    <= streak_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> design/fdm_stat_mem.sv
// Per-task statistics memory with one registered read port and one write port.
// Depends on fdm_pkg; entries never written read back as the reset entry.
module fdm_stat_mem #(
    parameter int NUM_TASKS = 6,
    parameter int AW = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output fdm_pkg::stat_entry_t rd_data,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  fdm_pkg::stat_entry_t wr_data
);
    import fdm_pkg::*;

    stat_entry_t mem [NUM_TASKS];
    logic [NUM_TASKS-1:0] written_reg;
    stat_entry_t rd_q_reg;
    logic rd_written_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_written_reg <= written_reg[rd_addr];
            end
        end
    end

    // An entry not yet written since reset stands for the cleared statistics.
    assign rd_data = rd_written_reg ? rd_q_reg : STAT_INIT;

endmodule
